// ----- hw/rtl/fqks_pkg.sv -----
// Shared types, constants and helpers of the frame queue with key-frame skip.
`default_nettype none

package fqks_pkg;

  // Number of descriptor slots in the queue.
  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed widths of the item fields.
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned PRES_W     = 64;
  localparam int unsigned ARRIVAL_W  = 32;
  localparam int unsigned SLOT_OUT_W = 5;
  localparam int unsigned FILL_OUT_W = 6;

  // Depth of the command queue between the front and the back.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Action codes as they arrive on the input.
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_GET   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_GET,
    OP_FLUSH,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [SIZE_W-1:0]    size;
    logic                 key;
    logic [PRES_W-1:0]    presentation;
    logic [ARRIVAL_W-1:0] arrival;
  } desc_t;

  typedef struct packed {
    op_e   op;
    desc_t desc;
  } cmd_t;

  typedef struct packed {
    logic                  put_accepted;
    logic                  frame_valid;
    logic [SLOT_OUT_W-1:0] slot_index;
    desc_t                 desc;
    logic [FILL_OUT_W-1:0] fill_level;
  } res_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] nxt;
    if (slot == SLOT_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = slot + SLOT_W'(1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fqks_front.sv -----
// Front part: accepts input items, decodes the action and queues commands for the back part.
`default_nettype none

module fqks_front import fqks_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ACTION_W-1:0]  action_i,
  input  wire logic [SIZE_W-1:0]    frame_size_i,
  input  wire logic                 is_key_i,
  input  wire logic [PRES_W-1:0]    presentation_time_i,
  input  wire logic [ARRIVAL_W-1:0] arrival_time_i,
  output logic                      cmd_valid_o,
  input  wire logic                 cmd_ready_i,
  output cmd_t                      cmd_o
);

  cmd_t                  slots_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  cmd_t                  dec_cmd;
  logic                  push, pop;

  always_comb begin
    dec_cmd.desc.size         = frame_size_i;
    dec_cmd.desc.key          = is_key_i;
    dec_cmd.desc.presentation = presentation_time_i;
    dec_cmd.desc.arrival      = arrival_time_i;
    case (action_i)
      ACT_PUT:   dec_cmd.op = OP_PUT;
      ACT_GET:   dec_cmd.op = OP_GET;
      ACT_FLUSH: dec_cmd.op = OP_FLUSH;
      default:   dec_cmd.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slots_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + CMDQ_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + CMDQ_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CMDQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fqks_back.sv -----
// Back part: descriptor store, queue pointers, key-frame walk and the result register.
`default_nettype none

module fqks_back import fqks_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire cmd_t cmd_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  desc_t             mem_q [QUEUE_DEPTH];
  desc_t             rdata_q;
  logic              state_q, state_d;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [SLOT_W-1:0] read_slot_q, read_slot_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              res_valid_q;
  res_t              res_q, res_d;
  logic              out_free, take_cmd, load_res, wr_en;

  assign out_free    = !res_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign take_cmd    = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d      = state_q;
    write_slot_d = write_slot_q;
    read_slot_d  = read_slot_q;
    pos_d        = pos_q;
    count_d      = count_q;
    load_res     = 1'b0;
    wr_en        = 1'b0;
    res_d        = '0;
    case (state_q)
      ST_IDLE: begin
        if (take_cmd) begin
          case (cmd_i.op)
            OP_PUT: begin
              load_res = 1'b1;
              if (count_q < CNT_W'(QUEUE_DEPTH)) begin
                wr_en              = 1'b1;
                write_slot_d       = next_slot(write_slot_q);
                count_d            = count_q + CNT_W'(1);
                res_d.put_accepted = 1'b1;
              end
            end
            OP_GET: begin
              if (count_q == '0) begin
                load_res = 1'b1;
              end else begin
                // Pop the head; its descriptor is read out in this cycle.
                pos_d       = read_slot_q;
                read_slot_d = next_slot(read_slot_q);
                count_d     = count_q - CNT_W'(1);
                state_d     = ST_WALK;
              end
            end
            OP_FLUSH: begin
              load_res     = 1'b1;
              write_slot_d = '0;
              read_slot_d  = '0;
              count_d      = '0;
            end
            default: begin
              load_res = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        // The read data holds the entry at pos_q, which has already been popped.
        if (count_q == '0 || rdata_q.key) begin
          load_res          = 1'b1;
          res_d.frame_valid = 1'b1;
          res_d.slot_index  = SLOT_OUT_W'(pos_q);
          res_d.desc        = rdata_q;
          state_d           = ST_IDLE;
        end else begin
          pos_d       = read_slot_q;
          read_slot_d = next_slot(read_slot_q);
          count_d     = count_q - CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res_d.fill_level = FILL_OUT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      write_slot_q <= '0;
      read_slot_q  <= '0;
      pos_q        <= '0;
      count_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      write_slot_q <= write_slot_d;
      read_slot_q  <= read_slot_d;
      pos_q        <= pos_d;
      count_q      <= count_d;
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= res_d;
    end
  end

  // Descriptor store: one write port, one registered read port at the head slot.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[write_slot_q] <= cmd_i.desc;
    end
    rdata_q <= mem_q[read_slot_q];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/frame_queue_key_skip_core.sv -----
// Top level of the frame descriptor queue with skip to the oldest key frame.
`default_nettype none

// A circular queue of 32 video frame descriptors. Every accepted item gives exactly one
// result. Items pass through a two-entry command queue into the execution unit; a put,
// flush or ignored action is carried out there directly, and its result appears in the
// next cycle. A get pops entries until it has popped a key frame or emptied the queue,
// and the walk reads the descriptor memory through its single registered read port,
// one entry per cycle. Items are taken by the command queue while a get is still walking,
// as long as that queue has room.
module frame_queue_key_skip_core import fqks_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ACTION_W-1:0]   action_i,
  input  wire logic [SIZE_W-1:0]     frame_size_i,
  input  wire logic                  is_key_i,
  input  wire logic [PRES_W-1:0]     presentation_time_i,
  input  wire logic [ARRIVAL_W-1:0]  arrival_time_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       put_accepted_o,
  output logic                       frame_valid_o,
  output logic [SLOT_OUT_W-1:0]      slot_index_o,
  output logic [SIZE_W-1:0]          out_size_o,
  output logic                       out_key_o,
  output logic [PRES_W-1:0]          out_presentation_o,
  output logic [ARRIVAL_W-1:0]       out_arrival_o,
  output logic [FILL_OUT_W-1:0]      fill_level_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  fqks_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .frame_size_i        (frame_size_i),
    .is_key_i            (is_key_i),
    .presentation_time_i (presentation_time_i),
    .arrival_time_i      (arrival_time_i),
    .cmd_valid_o         (cmd_valid),
    .cmd_ready_i         (cmd_ready),
    .cmd_o               (cmd)
  );

  fqks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign put_accepted_o     = res.put_accepted;
  assign frame_valid_o      = res.frame_valid;
  assign slot_index_o       = res.slot_index;
  assign out_size_o         = res.desc.size;
  assign out_key_o          = res.desc.key;
  assign out_presentation_o = res.desc.presentation;
  assign out_arrival_o      = res.desc.arrival;
  assign fill_level_o       = res.fill_level;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the frame descriptor queue with skip to the oldest key frame.
`timescale 1ns / 100ps

module tb;
  import fqks_pkg::*;

  localparam int unsigned ITEM_TARGET = 750;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned IDLE_PCT    = 9;

  // Keeps its own copy of the queue and works out the result of every transfer.
  class frame_queue_scoreboard;
    desc_t             slots[QUEUE_DEPTH];
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    int unsigned       level;
    res_t              pending_results[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       n_put;
    int unsigned       n_drop;
    int unsigned       n_get;
    int unsigned       n_empty_get;
    int unsigned       n_skipped;
    int unsigned       n_flush;
    int unsigned       n_nop;

    function new();
      head = '0;
      tail = '0;
      level = 0;
      errors = 0;
      checked = 0;
      n_put = 0;
      n_drop = 0;
      n_get = 0;
      n_empty_get = 0;
      n_skipped = 0;
      n_flush = 0;
      n_nop = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] s);
      return SLOT_W'((int'(s) + 1) % QUEUE_DEPTH);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_accepted(input logic [ACTION_W-1:0] act, input desc_t d);
      res_t              exp_res;
      logic [SLOT_W-1:0] pos;
      exp_res = '0;
      case (act)
        ACT_PUT: begin
          n_put++;
          if (level < QUEUE_DEPTH) begin
            slots[tail] = d;
            tail = advance(tail);
            level++;
            exp_res.put_accepted = 1'b1;
          end else begin
            n_drop++;
          end
        end
        ACT_GET: begin
          n_get++;
          if (level > 0) begin
            pos = head;
            head = advance(head);
            level--;
            // Keep popping until a key frame has been popped or nothing is left.
            while (level > 0 && !slots[pos].key) begin
              n_skipped++;
              pos = head;
              head = advance(head);
              level--;
            end
            exp_res.frame_valid = 1'b1;
            exp_res.slot_index = SLOT_OUT_W'(pos);
            exp_res.desc = slots[pos];
          end else begin
            n_empty_get++;
          end
        end
        ACT_FLUSH: begin
          n_flush++;
          head = '0;
          tail = '0;
          level = 0;
        end
        default: begin
          n_nop++;
        end
      endcase
      exp_res.fill_level = FILL_OUT_W'(level);
      pending_results.push_back(exp_res);
    endfunction

    task report_mismatch(input string field, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h", $time, checked, field, got,
               want);
    endtask

    task check_result(input res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, fill_level", 64'(got.fill_level), 64'd0);
        return;
      end
      want = pending_results.pop_front();
      if (got.put_accepted !== want.put_accepted)
        report_mismatch("put_accepted", 64'(got.put_accepted), 64'(want.put_accepted));
      if (got.frame_valid !== want.frame_valid)
        report_mismatch("frame_valid", 64'(got.frame_valid), 64'(want.frame_valid));
      if (got.slot_index !== want.slot_index)
        report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
      if (got.desc.size !== want.desc.size)
        report_mismatch("out_size", 64'(got.desc.size), 64'(want.desc.size));
      if (got.desc.key !== want.desc.key)
        report_mismatch("out_key", 64'(got.desc.key), 64'(want.desc.key));
      if (got.desc.presentation !== want.desc.presentation)
        report_mismatch("out_presentation", got.desc.presentation, want.desc.presentation);
      if (got.desc.arrival !== want.desc.arrival)
        report_mismatch("out_arrival", 64'(got.desc.arrival), 64'(want.desc.arrival));
      if (got.fill_level !== want.fill_level)
        report_mismatch("fill_level", 64'(got.fill_level), 64'(want.fill_level));
      checked++;
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [ACTION_W-1:0]   action_i = '0;
  logic [SIZE_W-1:0]     frame_size_i = '0;
  logic                  is_key_i = 1'b0;
  logic [PRES_W-1:0]     presentation_time_i = '0;
  logic [ARRIVAL_W-1:0]  arrival_time_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  put_accepted_o;
  logic                  frame_valid_o;
  logic [SLOT_OUT_W-1:0] slot_index_o;
  logic [SIZE_W-1:0]     out_size_o;
  logic                  out_key_o;
  logic [PRES_W-1:0]     out_presentation_o;
  logic [ARRIVAL_W-1:0]  out_arrival_o;
  logic [FILL_OUT_W-1:0] fill_level_o;

  frame_queue_scoreboard sb;
  bit                    steady = 1'b0;
  int unsigned           cycles = 0;
  int unsigned           sent = 0;

  frame_queue_key_skip_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .frame_size_i,
    .is_key_i,
    .presentation_time_i,
    .arrival_time_i,
    .out_valid_o,
    .out_ready_i,
    .put_accepted_o,
    .frame_valid_o,
    .slot_index_o,
    .out_size_o,
    .out_key_o,
    .out_presentation_o,
    .out_arrival_o,
    .fill_level_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic desc_t random_desc(input int unsigned key_pct);
    desc_t d;
    d.size = SIZE_W'($urandom);
    d.key = ($urandom_range(99) < key_pct);
    d.presentation = {$urandom, $urandom};
    d.arrival = $urandom;
    case ($urandom_range(15))
      0: d.size = '0;
      1: d.size = '1;
      2: d.presentation = '1;
      3: d.arrival = '0;
      default: ;
    endcase
    return d;
  endfunction

  // Presents one item and returns at the edge where it is transferred.
  task automatic send_item(input logic [ACTION_W-1:0] act, input desc_t d);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    frame_size_i <= d.size;
    is_key_i <= d.key;
    presentation_time_i <= d.presentation;
    arrival_time_i <= d.arrival;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_accepted(act, d);
    sent++;
  endtask

  // Result side: random back-pressure, and every transfer checked in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{put_accepted: put_accepted_o, frame_valid: frame_valid_o,
                        slot_index: slot_index_o,
                        desc: '{size: out_size_o, key: out_key_o,
                                presentation: out_presentation_o, arrival: out_arrival_o},
                        fill_level: fill_level_o});
    end
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
             sb.pending());
    $display("frame_queue_key_skip_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned block_len;
    int unsigned key_pct;
    int unsigned put_pct;
    int unsigned get_pct;
    int unsigned pick;
    int unsigned n;
    logic [ACTION_W-1:0] act;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty reads, the unused action code, extreme descriptors, skips, flush.
    send_item(ACT_GET, random_desc(50));
    send_item(ACTION_W'(OP_NOP), random_desc(50));
    send_item(ACT_PUT, '{size: '1, key: 1'b1, presentation: '1, arrival: '1});
    send_item(ACT_PUT, '{size: '0, key: 1'b0, presentation: '0, arrival: '0});
    send_item(ACT_PUT, random_desc(0));
    send_item(ACTION_W'(OP_NOP), '{size: '1, key: 1'b1, presentation: '1, arrival: '1});
    send_item(ACT_GET, random_desc(50));
    send_item(ACT_GET, random_desc(50));
    send_item(ACT_GET, random_desc(50));
    repeat (3) send_item(ACT_PUT, random_desc(0));
    send_item(ACT_PUT, random_desc(100));
    send_item(ACT_PUT, random_desc(0));
    send_item(ACT_GET, random_desc(50));
    send_item(ACT_FLUSH, random_desc(50));
    send_item(ACT_GET, random_desc(50));
    send_item(ACT_PUT, random_desc(0));
    send_item(ACT_PUT, random_desc(100));
    send_item(ACT_FLUSH, random_desc(50));
    send_item(ACT_PUT, random_desc(0));
    send_item(ACT_GET, random_desc(50));

    // The first random block fills the queue past the brim so that puts get turned away.
    for (n = 0; n < QUEUE_DEPTH + 4; n++) send_item(ACT_PUT, random_desc(20));
    send_item(ACT_GET, random_desc(50));

    while (sent < ITEM_TARGET) begin
      block_len = $urandom_range(60, 20);
      case ($urandom_range(2))
        0: key_pct = 5;
        1: key_pct = 25;
        default: key_pct = 60;
      endcase
      case ($urandom_range(2))
        0: begin put_pct = 90; get_pct = 8; end
        1: begin put_pct = 35; get_pct = 60; end
        default: begin put_pct = 55; get_pct = 38; end
      endcase
      for (n = 0; n < block_len; n++) begin
        // A stretch in the middle of the run goes without any idling on either side.
        steady = (sent >= 300 && sent < 420);
        pick = $urandom_range(99);
        if (pick < put_pct) act = ACT_PUT;
        else if (pick < put_pct + get_pct) act = ACT_GET;
        else if (pick < put_pct + get_pct + 1) act = ACTION_W'(OP_NOP);
        else act = ACT_FLUSH;
        send_item(act, random_desc(key_pct));
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d items: %0d puts (%0d turned away full), %0d gets (%0d on empty).",
             sent, sb.n_put, sb.n_drop, sb.n_get, sb.n_empty_get);
    $display("%0d frames skipped, %0d flushes, %0d unused codes, %0d results checked.",
             sb.n_skipped, sb.n_flush, sb.n_nop, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("frame_queue_key_skip_core regression: pass");
    end else begin
      $display("frame_queue_key_skip_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- frame_queue_key_skip_core.f -----
hw/rtl/fqks_pkg.sv
hw/rtl/fqks_front.sv
hw/rtl/fqks_back.sv
hw/rtl/frame_queue_key_skip_core.sv
tb/tb.sv
